// ===== hw/rtl/channel_packet_queue_manager_macros.svh =====
// Assertion macros for the channel packet queue manager.
// Each macro samples on clk and is disabled while rst is high.
`ifndef CHANNEL_PACKET_QUEUE_MANAGER_MACROS_SVH
`define CHANNEL_PACKET_QUEUE_MANAGER_MACROS_SVH

// Condition must hold at every edge.
`define CPQM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cpqm assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CPQM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpqm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CPQM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpqm assertion failed");

`endif

// ===== hw/rtl/cpqm_pkg.sv =====
// Package for the channel packet queue manager: op and status codes,
// sequencer states, op classes and the per-class step plan. No dependencies.
`timescale 1ns / 1ps

package cpqm_pkg;

  localparam int OP_W     = 4;
  localparam int CHAN_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int HANDLE_W = 16;
  localparam int LIFE_W   = 32;
  localparam int NOW_W    = 48;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int DLOUT_W  = 48;
  localparam int STEP_W   = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ     = 4'd0;
  localparam logic [OP_W-1:0] OP_PEEK    = 4'd1;
  localparam logic [OP_W-1:0] OP_PEEK_DS = 4'd2;
  localparam logic [OP_W-1:0] OP_ERAS_DS = 4'd3;
  localparam logic [OP_W-1:0] OP_ERASE   = 4'd4;
  localparam logic [OP_W-1:0] OP_CLOSE   = 4'd5;
  localparam logic [OP_W-1:0] OP_SIZE    = 4'd6;
  localparam logic [OP_W-1:0] OP_MV_DS   = 4'd7;
  localparam logic [OP_W-1:0] OP_MV_ALL  = 4'd8;
  localparam logic [OP_W-1:0] OP_FLOWS   = 4'd9;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_OPEN, S_CLOSE, S_LOADA, S_LOADB, S_PURGEA, S_PURGEB,
    S_APPEND, S_HEAD, S_FILTER, S_FLOWS, S_STOREA, S_STOREB, S_NEXTQ, S_DONE
  } st_t;

  typedef enum logic [3:0] {
    C_NONE, C_ENQ, C_FRONT, C_DEST, C_CLOSE, C_SIZE, C_MOVE, C_MOVE_FAIL, C_FLOWS
  } cls_t;

  // Action taken at a given step of an op class
  function automatic st_t plan_act(cls_t c, logic [STEP_W-1:0] s);
    st_t r;
    r = S_DONE;
    unique case (c)
      C_ENQ: begin
        case (s)
          5'd0: r = S_OPEN;
          5'd1: r = S_LOADA;
          5'd2: r = S_PURGEA;
          5'd3: r = S_APPEND;
          5'd4: r = S_STOREA;
          default: r = S_DONE;
        endcase
      end
      C_FRONT: begin
        case (s)
          5'd0: r = S_LOADA;
          5'd1: r = S_PURGEA;
          5'd2: r = S_HEAD;
          5'd3: r = S_STOREA;
          default: r = S_DONE;
        endcase
      end
      C_DEST: begin
        case (s)
          5'd0: r = S_LOADA;
          5'd1: r = S_PURGEA;
          5'd2: r = S_FILTER;
          5'd3: r = S_STOREA;
          default: r = S_DONE;
        endcase
      end
      C_CLOSE: begin
        case (s)
          5'd0: r = S_CLOSE;
          default: r = S_DONE;
        endcase
      end
      C_SIZE: begin
        case (s)
          5'd0: r = S_LOADA;
          5'd1: r = S_PURGEA;
          5'd2: r = S_STOREA;
          default: r = S_DONE;
        endcase
      end
      C_MOVE: begin
        case (s)
          5'd0, 5'd8:   r = (s == 5'd0) ? S_OPEN : S_NEXTQ;
          5'd1, 5'd9:   r = S_LOADA;
          5'd2, 5'd10:  r = S_LOADB;
          5'd3, 5'd11:  r = S_PURGEA;
          5'd4, 5'd12:  r = S_PURGEB;
          5'd5, 5'd13:  r = S_FILTER;
          5'd6, 5'd14:  r = S_STOREA;
          5'd7, 5'd15:  r = S_STOREB;
          default: r = S_DONE;
        endcase
      end
      C_MOVE_FAIL: begin
        case (s)
          5'd0: r = S_OPEN;
          default: r = S_DONE;
        endcase
      end
      C_FLOWS: begin
        case (s)
          5'd0: r = S_LOADA;
          5'd1: r = S_PURGEA;
          5'd2: r = S_FLOWS;
          5'd3: r = S_STOREA;
          default: r = S_DONE;
        endcase
      end
      default: r = S_DONE;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpqm_cmd_if.sv =====
// Command channel of the queue manager: valid/ready plus one op item.
// Depends on cpqm_pkg for field widths.
`timescale 1ns / 1ps

interface cpqm_cmd_if;
  import cpqm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [CHAN_W-1:0]     channel;
  logic [CHAN_W-1:0]     target_channel;
  logic                  is_hello;
  logic [ADDR_W-1:0]     dest_addr;
  logic [ADDR_W-1:0]     origin_addr;
  logic [HANDLE_W-1:0]   packet_handle;
  logic [LIFE_W-1:0]     lifetime;
  logic [NOW_W-1:0]      now_time;

  modport source (output valid, op, channel, target_channel, is_hello, dest_addr,
                  origin_addr, packet_handle, lifetime, now_time, input ready);
  modport sink (input valid, op, channel, target_channel, is_hello, dest_addr,
                origin_addr, packet_handle, lifetime, now_time, output ready);
endinterface

// ===== hw/rtl/cpqm_rsp_if.sv =====
// Result channel of the queue manager: valid/ready plus one result item.
// Depends on cpqm_pkg for field widths.
`timescale 1ns / 1ps

interface cpqm_rsp_if;
  import cpqm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [COUNT_W-1:0]    count;
  logic [HANDLE_W-1:0]   out_handle;
  logic [ADDR_W-1:0]     out_dest;
  logic [ADDR_W-1:0]     out_origin;
  logic [DLOUT_W-1:0]    out_deadline;

  modport source (output valid, status, count, out_handle, out_dest, out_origin,
                  out_deadline, input ready);
  modport sink (input valid, status, count, out_handle, out_dest, out_origin,
                out_deadline, output ready);
endinterface

// ===== hw/rtl/cpqm_mem.sv =====
// Entry store of the queue manager: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module cpqm_mem #(
  parameter int AW = 10,
  parameter int DW = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/channel_packet_queue_manager.sv =====
// Channel packet queue manager: per-channel data and hello descriptor queues.
// Depends on cpqm_pkg, cpqm_cmd_if, cpqm_rsp_if, cpqm_mem and the macro header.
//
// Usage:
//   cmd carries one operation item (valid/ready); rsp returns exactly one
//   result item per operation. cmd.ready is high only while the sequencer
//   is idle; one item is worked on at a time.
//   All entries live in one single-port-read, single-port-write memory; a
//   small sequencer walks it one entry per read. Expired head entries are
//   purged and searches and moves scan their queue entry by entry; flow
//   counting compares each entry's origin with those of the earlier
//   entries. The sequencer returns to idle before the next accept.
//   The result sits in an output register; the next item is accepted while
//   it waits, and a finished item waits in its last state if the receiver
//   still stalls the previous result.
//   Reset (rst, synchronous) clears all channels and queue lengths at once;
//   the entry memory needs no clearing pass.
`timescale 1ns / 1ps
`include "channel_packet_queue_manager_macros.svh"

module channel_packet_queue_manager #(
  parameter int CHANNELS    = 16,
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input logic       clk,
  input logic       rst,
  cpqm_cmd_if.sink   cmd,
  cpqm_rsp_if.source rsp
);
  import cpqm_pkg::*;

  localparam int CH_W = $clog2(CHANNELS);
  localparam int QW   = CH_W + 1;
  localparam int NQ   = 2 * CHANNELS;
  localparam int SW   = $clog2(QUEUE_DEPTH);
  localparam int LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CW   = $clog2(2 * QUEUE_DEPTH + 1);
  localparam int AW   = QW + SW;
  localparam int DW   = HANDLE_W + 2 * ADDR_W + TIME_BITS;
  localparam int SUMW = ((TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W) + 1;
  localparam logic [SUMW-1:0] TMAX = {{(SUMW - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
  localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

  // Position of entry k of a circular queue whose head is h
  function automatic logic [SW-1:0] qpos(logic [SW-1:0] h, logic [LW-1:0] k);
    logic [LW:0] s;
    s = (LW + 1)'(h) + (LW + 1)'(k);
    if (s >= (LW + 1)'(QUEUE_DEPTH)) begin
      s = s - (LW + 1)'(QUEUE_DEPTH);
    end
    return SW'(s);
  endfunction

  st_t state, state_next;
  cls_t cls, cls_d;
  logic [STEP_W-1:0] step, step_inc;
  logic [1:0] phase;
  logic fin;

  // Latched command
  logic [OP_W-1:0]     r_op;
  logic [CHAN_W-1:0]   r_ch, r_tc;
  logic                r_hel;
  logic [ADDR_W-1:0]   r_dest, r_orig;
  logic [HANDLE_W-1:0] r_hnd;
  logic [TIME_BITS-1:0] r_now;
  logic [SUMW-1:0]     dl_sum;
  logic [TIME_BITS-1:0] dl_sat;

  // Channel and queue bookkeeping
  logic [CHANNELS-1:0] exists, closed;
  logic [LW-1:0] len_arr  [NQ];
  logic [SW-1:0] head_arr [NQ];

  // Working copies of the two queues in use
  logic [QW-1:0] a_q, b_q;
  logic [LW-1:0] a_len, b_len;
  logic [SW-1:0] a_head, b_head;
  logic [LW-1:0] i, w, j;
  logic [CW-1:0] cnt;
  logic [STAT_W-1:0] status;
  logic blocked, matched;
  logic [ADDR_W-1:0] org;
  logic [DW-1:0] found_e;

  // Result register
  logic rsp_v;
  logic [STAT_W-1:0] rsp_status;
  logic [COUNT_W-1:0] rsp_count;
  logic [DW-1:0] rsp_e;

  // Memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, rdata;

  logic [CH_W-1:0] chi, tci, oc;
  logic ch_ok, tc_ok, ch_open;
  logic [ADDR_W-1:0] e_dest, e_orig;
  logic [TIME_BITS-1:0] e_dl;
  logic e_exp, e_match, e_take, b_room;

  cpqm_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Field view of the entry just read, shared compare unit
  assign e_dest  = rdata[DW-HANDLE_W-1 -: ADDR_W];
  assign e_orig  = rdata[DW-HANDLE_W-ADDR_W-1 -: ADDR_W];
  assign e_dl    = rdata[TIME_BITS-1:0];
  assign e_exp   = e_dl < r_now;
  assign e_match = e_dest == r_dest;
  assign e_take  = !e_exp && ((r_op == OP_MV_ALL) || e_match);
  assign b_room  = b_len < DEPTH_L;

  assign chi     = CH_W'(r_ch);
  assign tci     = CH_W'(r_tc);
  assign ch_ok   = 32'(r_ch) < CHANNELS;
  assign tc_ok   = 32'(r_tc) < CHANNELS;
  assign ch_open = ch_ok && exists[chi] && !closed[chi];
  assign oc      = (r_op == OP_ENQ) ? chi : tci;
  assign dl_sat  = (dl_sum > TMAX) ? TIME_BITS'(TMAX) : TIME_BITS'(dl_sum);
  assign step_inc = step + STEP_W'(1);

  // Decode the latched op into a class
  always_comb begin
    cls_d = C_NONE;
    if (ch_ok) begin
      unique case (r_op) inside
        OP_ENQ:               cls_d = C_ENQ;
        OP_PEEK, OP_ERASE:    cls_d = ch_open ? C_FRONT : C_NONE;
        OP_PEEK_DS, OP_ERAS_DS: cls_d = ch_open ? C_DEST : C_NONE;
        OP_CLOSE:             cls_d = exists[chi] ? C_CLOSE : C_NONE;
        OP_SIZE:              cls_d = ch_open ? C_SIZE : C_NONE;
        OP_MV_DS, OP_MV_ALL: begin
          if (tc_ok && (r_tc != r_ch)) begin
            cls_d = ch_open ? C_MOVE : C_MOVE_FAIL;
          end
        end
        OP_FLOWS:             cls_d = ch_open ? C_FLOWS : C_NONE;
        default:              cls_d = C_NONE;
      endcase
    end
  end

  // Next state
  always_comb begin
    fin = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.valid) state_next = S_DECODE;
      S_DECODE: state_next = plan_act(cls_d, '0);
      S_OPEN, S_CLOSE, S_LOADA, S_LOADB, S_APPEND, S_HEAD, S_STOREA, S_STOREB:
        fin = 1'b1;
      S_PURGEA: fin = (phase == 2'd0) ? (a_len == '0) : !e_exp;
      S_PURGEB: fin = (phase == 2'd0) ? (b_len == '0) : !e_exp;
      S_FILTER: fin = (phase == 2'd0) ? (i >= a_len) : ((r_op == OP_PEEK_DS) && e_match);
      S_FLOWS:  fin = (phase == 2'd0) && (i >= a_len);
      S_NEXTQ:  if (r_op == OP_MV_ALL) fin = 1'b1; else state_next = S_DONE;
      S_DONE:   if (!rsp_v || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
    if (fin) begin
      state_next = plan_act(cls, step_inc);
    end
  end

  // Outputs: handshake and memory port
  always_comb begin
    cmd.ready = (state == S_IDLE);
    mem_re = 1'b0;
    mem_raddr = '0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    unique case (state)
      S_PURGEA: begin
        mem_re = (phase == 2'd0) && (a_len != '0);
        mem_raddr = {a_q, a_head};
      end
      S_PURGEB: begin
        mem_re = (phase == 2'd0) && (b_len != '0);
        mem_raddr = {b_q, b_head};
      end
      S_APPEND: begin
        mem_we = a_len < DEPTH_L;
        mem_waddr = {a_q, qpos(a_head, a_len)};
        mem_wdata = {r_hnd, r_dest, r_orig, dl_sat};
      end
      S_FILTER: begin
        mem_re = (phase == 2'd0) && (i < a_len);
        mem_raddr = {a_q, qpos(a_head, i)};
        if (phase == 2'd1) begin
          case (r_op) inside
            OP_ERAS_DS: begin
              mem_we = matched || !e_match;
              mem_waddr = {a_q, qpos(a_head, w)};
            end
            OP_MV_DS, OP_MV_ALL: begin
              mem_we = 1'b1;
              if (e_take && b_room) begin
                mem_waddr = {b_q, qpos(b_head, b_len)};
              end else begin
                mem_waddr = {a_q, qpos(a_head, w)};
              end
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      S_FLOWS: begin
        if (phase == 2'd0) begin
          mem_re = i < a_len;
          mem_raddr = {a_q, qpos(a_head, i)};
        end else if (phase == 2'd2) begin
          mem_re = j < i;
          mem_raddr = {a_q, qpos(a_head, j)};
        end
      end
      default: mem_re = 1'b0;
    endcase
  end

  assign rsp.valid        = rsp_v;
  assign rsp.status       = rsp_status;
  assign rsp.count        = rsp_count;
  assign rsp.out_handle   = rsp_e[DW-1 -: HANDLE_W];
  assign rsp.out_dest     = rsp_e[DW-HANDLE_W-1 -: ADDR_W];
  assign rsp.out_origin   = rsp_e[DW-HANDLE_W-ADDR_W-1 -: ADDR_W];
  assign rsp.out_deadline = DLOUT_W'(rsp_e[TIME_BITS-1:0]);

  // Sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rsp_v  <= 1'b0;
      exists <= '0;
      closed <= '0;
      for (int k = 0; k < NQ; k++) begin
        len_arr[k]  <= '0;
        head_arr[k] <= '0;
      end
    end else begin
      state <= state_next;
      // Raise the result when done, drop it once taken
      if (state == S_DONE && state_next == S_IDLE) begin
        rsp_v <= 1'b1;
      end else if (rsp_v && rsp.ready) begin
        rsp_v <= 1'b0;
      end
      if (fin) begin
        step  <= step_inc;
        phase <= 2'd0;
        i <= '0;
        w <= '0;
        j <= '0;
      end
      unique case (state)
        S_IDLE: begin
          // Latch the command item
          if (cmd.valid) begin
            r_op   <= cmd.op;
            r_ch   <= cmd.channel;
            r_tc   <= cmd.target_channel;
            r_hel  <= cmd.is_hello;
            r_dest <= cmd.dest_addr;
            r_orig <= cmd.origin_addr;
            r_hnd  <= cmd.packet_handle;
            r_now  <= TIME_BITS'(cmd.now_time);
            dl_sum <= SUMW'(TIME_BITS'(cmd.now_time)) + SUMW'(cmd.lifetime);
          end
        end
        S_DECODE: begin
          cls     <= cls_d;
          step    <= '0;
          phase   <= 2'd0;
          i <= '0;
          w <= '0;
          j <= '0;
          cnt     <= '0;
          blocked <= 1'b0;
          matched <= 1'b0;
          found_e <= '0;
          status  <= ((r_op == OP_SIZE && ch_ok) || (cls_d == C_FLOWS) ||
                      ((r_op == OP_MV_DS || r_op == OP_MV_ALL) && ch_ok && tc_ok &&
                       r_tc == r_ch)) ? ST_OK : ST_MISS;
          if (r_op == OP_ENQ || r_op == OP_PEEK || r_op == OP_ERASE || r_op == OP_SIZE) begin
            a_q <= {chi, r_hel};
          end else begin
            a_q <= {chi, 1'b0};
          end
          b_q <= {tci, 1'b0};
        end
        S_OPEN: begin
          // Create or reopen the channel with empty queues
          if (!(exists[oc] && !closed[oc])) begin
            exists[oc] <= 1'b1;
            closed[oc] <= 1'b0;
            len_arr[{oc, 1'b0}] <= '0;
            len_arr[{oc, 1'b1}] <= '0;
          end
        end
        S_CLOSE: begin
          closed[chi] <= 1'b1;
          len_arr[{chi, 1'b0}] <= '0;
          len_arr[{chi, 1'b1}] <= '0;
          status <= ST_OK;
        end
        S_LOADA: begin
          a_len  <= len_arr[a_q];
          a_head <= head_arr[a_q];
        end
        S_LOADB: begin
          b_len  <= len_arr[b_q];
          b_head <= head_arr[b_q];
        end
        S_PURGEA: begin
          // Drop expired head entries
          if (phase == 2'd0) begin
            if (a_len != '0) phase <= 2'd1;
          end else if (e_exp) begin
            a_head <= qpos(a_head, LW'(1));
            a_len  <= a_len - LW'(1);
            phase  <= 2'd0;
          end
        end
        S_PURGEB: begin
          if (phase == 2'd0) begin
            if (b_len != '0) phase <= 2'd1;
          end else if (e_exp) begin
            b_head <= qpos(b_head, LW'(1));
            b_len  <= b_len - LW'(1);
            phase  <= 2'd0;
          end
        end
        S_APPEND: begin
          if (a_len < DEPTH_L) begin
            a_len  <= a_len + LW'(1);
            status <= ST_OK;
          end else begin
            status <= ST_FULL;
          end
        end
        S_HEAD: begin
          if (a_len != '0) begin
            status <= ST_OK;
            if (r_op == OP_PEEK) begin
              found_e <= rdata;
            end else begin
              a_head <= qpos(a_head, LW'(1));
              a_len  <= a_len - LW'(1);
            end
          end
        end
        S_FILTER: begin
          // Scan the queue one entry at a time; erase and move also compact it
          if (phase == 2'd0) begin
            if (i < a_len) begin
              phase <= 2'd1;
            end else begin
              if (r_op != OP_PEEK_DS) a_len <= w;
              if (r_op == OP_MV_DS || r_op == OP_MV_ALL) begin
                status <= blocked ? ST_FULL : ST_OK;
              end
            end
          end else begin
            case (r_op) inside
              OP_PEEK_DS: begin
                if (e_match) begin
                  status  <= ST_OK;
                  found_e <= rdata;
                end else begin
                  i <= i + LW'(1);
                  phase <= 2'd0;
                end
              end
              OP_ERAS_DS: begin
                if (!matched && e_match) begin
                  matched <= 1'b1;
                  status  <= ST_OK;
                end else begin
                  w <= w + LW'(1);
                end
                i <= i + LW'(1);
                phase <= 2'd0;
              end
              default: begin
                if (e_take && b_room) begin
                  b_len <= b_len + LW'(1);
                  cnt   <= cnt + CW'(1);
                end else begin
                  if (e_take) blocked <= 1'b1;
                  w <= w + LW'(1);
                end
                i <= i + LW'(1);
                phase <= 2'd0;
              end
            endcase
          end
        end
        S_FLOWS: begin
          // Count entries whose origin did not appear earlier
          case (phase)
            2'd0: if (i < a_len) phase <= 2'd1;
            2'd1: begin
              org <= e_orig;
              j <= '0;
              phase <= 2'd2;
            end
            2'd2: begin
              if (j >= i) begin
                cnt <= cnt + CW'(1);
                i <= i + LW'(1);
                phase <= 2'd0;
              end else begin
                phase <= 2'd3;
              end
            end
            default: begin
              if (e_orig == org) begin
                i <= i + LW'(1);
                phase <= 2'd0;
              end else begin
                j <= j + LW'(1);
                phase <= 2'd2;
              end
            end
          endcase
        end
        S_STOREA: begin
          len_arr[a_q]  <= a_len;
          head_arr[a_q] <= a_head;
          if (cls == C_ENQ || cls == C_FRONT || cls == C_DEST || cls == C_SIZE) begin
            cnt <= CW'(a_len);
          end
        end
        S_STOREB: begin
          len_arr[b_q]  <= b_len;
          head_arr[b_q] <= b_head;
        end
        S_NEXTQ: begin
          // Switch to the hello queues
          a_q <= {a_q[QW-1:1], 1'b1};
          b_q <= {b_q[QW-1:1], 1'b1};
        end
        S_DONE: begin
          if (state_next == S_IDLE) begin
            rsp_status <= status;
            rsp_count  <= COUNT_W'(cnt);
            rsp_e      <= found_e;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `CPQM_ASSERT_NEXT(a_accept_decodes, cmd.valid && cmd.ready, state == S_DECODE)
  `CPQM_ASSERT_IMPLY(a_append_room, state == S_APPEND && mem_we, a_len < DEPTH_L)
  `CPQM_ASSERT_IMPLY(a_done_holds, state == S_DONE && rsp_v && !rsp.ready, state_next == S_DONE)

endmodule

// ===== test/channel_packet_queue_manager_tb.sv =====
// Testbench for the channel packet queue manager: drives op items through the
// command channel, predicts each result with a behavioral queue model and checks it.
// Depends on cpqm_pkg, cpqm_cmd_if, cpqm_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module channel_packet_queue_manager_tb;
  import cpqm_pkg::*;

  localparam int NCH = 16;
  localparam int DEPTH = 32;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 10000000;
  localparam int LONG_STALL = 400;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] dest;
    logic [31:0] origin;
    logic [47:0] deadline;
  } desc_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [15:0] handle;
    logic [31:0] dest;
    logic [31:0] origin;
    logic [47:0] deadline;
  } answer_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  channel;
    logic [3:0]  target;
    logic        hello;
    logic [31:0] dest;
    logic [31:0] origin;
    logic [15:0] handle;
    logic [31:0] life;
    logic [47:0] now;
  } cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  cpqm_cmd_if cmd ();
  cpqm_rsp_if rsp ();

  channel_packet_queue_manager dut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow state of the queues
  bit    ch_live [NCH];
  bit    ch_shut [NCH];
  desc_t fifo [2*NCH][$];

  answer_t pending_answers[$];
  int      errors = 0;
  int      cycles = 0;
  bit      rx_idle_on = 1'b1;
  bit      tx_idle_on = 1'b1;
  int      hold_rx = 0;
  int      stall_req = 0;
  int      stall_ack = 0;
  int      stall_left = 0;
  logic [47:0] clock_now = 48'd1000;
  logic [31:0] addr_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001};

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic bit chan_open(int c);
    return ch_live[c] && !ch_shut[c];
  endfunction

  function automatic void drop_expired(int q, logic [47:0] now);
    while (fifo[q].size() > 0 && fifo[q][0].deadline < now) void'(fifo[q].pop_front());
  endfunction

  function automatic void open_chan(int c);
    if (!ch_live[c] || ch_shut[c]) begin
      ch_live[c] = 1; ch_shut[c] = 0;
      fifo[2*c].delete(); fifo[2*c+1].delete();
    end
  endfunction

  function automatic void shift_entries(int o, int t, bit every, logic [31:0] key,
                                        logic [47:0] now, ref int moved, ref bit blocked);
    int i;
    i = 0;
    while (i < fifo[o].size()) begin
      if (fifo[o][i].deadline < now || (!every && fifo[o][i].dest != key)) begin
        i++;
      end else if (fifo[t].size() >= DEPTH) begin
        blocked = 1; i++;
      end else begin
        fifo[t].insert(fifo[t].size(), fifo[o][i]);
        fifo[o].delete(i);
        moved++;
      end
    end
  endfunction

  // Apply one op to the shadow state and return the answer it yields
  function automatic answer_t apply_op(cmd_t c);
    answer_t a;
    int q, dq, moved, n;
    bit blocked, seen;
    desc_t e;
    logic [48:0] sum;
    a = '0; a.status = ST_MISS;
    q = 2*c.channel + c.hello; dq = 2*c.channel;
    moved = 0; blocked = 0;
    if (c.op > OP_FLOWS) return a;
    case (c.op)
      OP_ENQ: begin
        open_chan(c.channel);
        drop_expired(q, c.now);
        sum = {1'b0, c.now} + {17'b0, c.life};
        e.handle = c.handle; e.dest = c.dest; e.origin = c.origin;
        e.deadline = sum[48] ? TMAX : sum[47:0];
        if (fifo[q].size() < DEPTH) begin
          fifo[q].insert(fifo[q].size(), e); a.status = ST_OK;
        end else a.status = ST_FULL;
        a.count = 7'(fifo[q].size());
      end
      OP_PEEK, OP_ERASE: if (chan_open(c.channel)) begin
        drop_expired(q, c.now);
        if (fifo[q].size() > 0) begin
          a.status = ST_OK;
          if (c.op == OP_PEEK) begin
            e = fifo[q][0];
            a.handle = e.handle; a.dest = e.dest; a.origin = e.origin; a.deadline = e.deadline;
          end else void'(fifo[q].pop_front());
        end
        a.count = 7'(fifo[q].size());
      end
      OP_PEEK_DS, OP_ERAS_DS: if (chan_open(c.channel)) begin
        drop_expired(dq, c.now);
        foreach (fifo[dq][i]) if (fifo[dq][i].dest == c.dest) begin
          a.status = ST_OK;
          if (c.op == OP_PEEK_DS) begin
            e = fifo[dq][i];
            a.handle = e.handle; a.dest = e.dest; a.origin = e.origin; a.deadline = e.deadline;
          end else fifo[dq].delete(i);
          break;
        end
        a.count = 7'(fifo[dq].size());
      end
      OP_CLOSE: if (ch_live[c.channel]) begin
        ch_shut[c.channel] = 1;
        fifo[2*c.channel].delete(); fifo[2*c.channel+1].delete();
        a.status = ST_OK;
      end
      OP_SIZE: begin
        a.status = ST_OK;
        if (chan_open(c.channel)) drop_expired(q, c.now);
        if (ch_live[c.channel]) a.count = 7'(fifo[q].size());
      end
      OP_MV_DS, OP_MV_ALL: begin
        if (c.target == c.channel) a.status = ST_OK;
        else begin
          open_chan(c.target);
          if (chan_open(c.channel)) begin
            drop_expired(dq, c.now); drop_expired(2*c.target, c.now);
            shift_entries(dq, 2*c.target, c.op == OP_MV_ALL, c.dest, c.now, moved, blocked);
            if (c.op == OP_MV_ALL) begin
              drop_expired(dq+1, c.now); drop_expired(2*c.target+1, c.now);
              shift_entries(dq+1, 2*c.target+1, 1'b1, 32'd0, c.now, moved, blocked);
            end
            a.status = blocked ? ST_FULL : ST_OK;
            a.count = 7'(moved);
          end
        end
      end
      default: if (chan_open(c.channel)) begin
        drop_expired(dq, c.now);
        a.status = ST_OK; n = 0;
        foreach (fifo[dq][i]) begin
          seen = 0;
          for (int j = 0; j < i; j++) if (fifo[dq][j].origin == fifo[dq][i].origin) seen = 1;
          if (!seen) n++;
        end
        a.count = 7'(n);
      end
    endcase
    return a;
  endfunction

  // Offer one item, predict on acceptance; valid stays up until the next item
  task automatic send_op(input cmd_t c);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op <= c.op; cmd.channel <= c.channel; cmd.target_channel <= c.target;
    cmd.is_hello <= c.hello; cmd.dest_addr <= c.dest; cmd.origin_addr <= c.origin;
    cmd.packet_handle <= c.handle; cmd.lifetime <= c.life; cmd.now_time <= c.now;
    do @(posedge clk); while (!cmd.ready);
    pending_answers.insert(pending_answers.size(), apply_op(c));
  endtask

  function automatic cmd_t make_op(logic [3:0] op, int ch, int hello = 0);
    cmd_t c;
    c.op = op; c.channel = 4'(ch); c.target = 4'($urandom_range(0, 15)); c.hello = hello[0];
    c.dest = addr_pool[$urandom_range(0, 3)];
    c.origin = addr_pool[$urandom_range(0, 3)] ^ 32'($urandom_range(0, 1));
    c.handle = 16'($urandom); c.life = 32'($urandom_range(0, 400)); c.now = clock_now;
    return c;
  endfunction

  task automatic wait_drain();
    cmd.valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    answer_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        report("unexpected result item", 64'd0, 64'd0);
      end else begin
        w = pending_answers.pop_front();
        if (rsp.status !== w.status) report("status", rsp.status, w.status);
        if (rsp.count !== w.count) report("count", rsp.count, w.count);
        if (rsp.out_handle !== w.handle) report("handle", rsp.out_handle, w.handle);
        if (rsp.out_dest !== w.dest) report("dest", rsp.out_dest, w.dest);
        if (rsp.out_origin !== w.origin) report("origin", rsp.out_origin, w.origin);
        if (rsp.out_deadline !== w.deadline) report("deadline", rsp.out_deadline, w.deadline);
      end
    end
  end

  // Long receiver stall: start on request, count down in cycles
  always @(posedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= LONG_STALL;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver readiness: random stall bursts, or the long stall
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
    end else if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      rsp.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      hold_rx <= $urandom_range(0, 12);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    cmd_t c;
    // Fill one data queue past full, with field extremes
    for (int i = 0; i < DEPTH + 1; i++) begin
      c = make_op(OP_ENQ, 3);
      c.handle = i[0] ? 16'hFFFF : 16'h0; c.life = 32'hFFFF_FFFF;
      c.dest = i[0] ? 32'hFFFF_FFFF : 32'h0; c.origin = i[1] ? 32'hFFFF_FFFF : 32'h0;
      send_op(c);
    end
    c = make_op(OP_ENQ, 15, 1); c.now = TMAX; c.life = 32'hFFFF_FFFF; send_op(c);
    c = make_op(OP_PEEK, 15, 1); c.now = TMAX; send_op(c);
    c = make_op(OP_SIZE, 15, 1); c.now = TMAX; send_op(c);
    c = make_op(OP_CLOSE, 15); send_op(c);
  endtask

  task automatic test_each_op();
    cmd_t c;
    for (int o = 0; o < 16; o++) begin
      c = make_op(4'(o), 3, o & 1); c.target = (o == 8) ? 4'd3 : 4'd5; send_op(c);
    end
    c = make_op(OP_PEEK, 9); send_op(c);      // absent channel
    c = make_op(OP_SIZE, 9); send_op(c);
    c = make_op(OP_CLOSE, 9); send_op(c);
    c = make_op(OP_MV_ALL, 10); c.target = 4'd11; send_op(c);  // absent origin opens target
  endtask

  task automatic test_full_queue();
    cmd_t c;
    wait_drain();
    for (int i = 0; i < DEPTH + 2; i++) begin
      c = make_op(OP_ENQ, 7); c.life = 32'hFFFF_FFFF; send_op(c);
    end
    for (int i = 0; i < 4; i++) begin
      c = make_op(OP_ENQ, 8); c.life = 32'hFFFF_FFFF; send_op(c);
    end
    c = make_op(OP_MV_ALL, 8); c.target = 4'd7; send_op(c);   // target full
    c = make_op(OP_FLOWS, 7); send_op(c);
  endtask

  task automatic test_backpressure();
    cmd_t c;
    wait_drain();
    stall_req = stall_req + 1;
    for (int i = 0; i < 30; i++) begin
      c = make_op(OP_ENQ, 1, i & 1); send_op(c);
    end
  endtask

  task automatic test_random(input int n, input bit idle);
    cmd_t c;
    int r;
    rx_idle_on = idle; tx_idle_on = idle;
    for (int i = 0; i < n; i++) begin
      clock_now = clock_now + 48'($urandom_range(0, 30));
      r = $urandom_range(0, 99);
      if (r < 40) c = make_op(OP_ENQ, $urandom_range(0, 5), $urandom_range(0, 1));
      else if (r < 95) c = make_op(4'($urandom_range(1, 9)), $urandom_range(0, 5),
                                   $urandom_range(0, 1));
      else begin
        c = make_op(4'($urandom_range(0, 15)), $urandom_range(0, 15), $urandom_range(0, 1));
        c.now = 48'({$urandom, $urandom});
        c.dest = $urandom; c.origin = $urandom; c.life = $urandom;
      end
      if (c.op == OP_MV_DS || c.op == OP_MV_ALL) c.target = 4'($urandom_range(0, 6));
      if (c.op == OP_CLOSE && $urandom_range(0, 3) != 0) c.op = OP_SIZE;
      send_op(c);
    end
  endtask

  initial begin
    cmd.valid = 1'b0; cmd.op = OP_ENQ; cmd.channel = '0; cmd.target_channel = '0;
    cmd.is_hello = 1'b0; cmd.dest_addr = '0; cmd.origin_addr = '0;
    cmd.packet_handle = '0; cmd.lifetime = '0; cmd.now_time = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_each_op();
    test_full_queue();
    test_backpressure();
    test_random(730, 1'b1);
    test_random(200, 1'b0);
    wait_drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cpqm_pkg.sv
hw/rtl/cpqm_cmd_if.sv
hw/rtl/cpqm_rsp_if.sv
hw/rtl/cpqm_mem.sv
hw/rtl/channel_packet_queue_manager.sv
test/channel_packet_queue_manager_tb.sv
